/* sv/rpd_pkg.sv */
// Shared types and constants for the RefPack stream decompressor.
// No dependencies.
package rpd_pkg;

  localparam int unsigned HistDepthDef = 131072;
  localparam int unsigned DistW        = 18;
  localparam int unsigned CountW       = 24;

  localparam logic [7:0] MagicByte = 8'hFB;

  localparam logic [2:0] ErrNone  = 3'd0;
  localparam logic [2:0] ErrMagic = 3'd1;
  localparam logic [2:0] ErrDist  = 3'd2;
  localparam logic [2:0] ErrOver  = 3'd3;
  localparam logic [2:0] ErrOrder = 3'd4;

  typedef enum logic [9:0] {
    PH_HDR0    = 10'b00_0000_0001,
    PH_HDR1    = 10'b00_0000_0010,
    PH_SKIP    = 10'b00_0000_0100,
    PH_SIZE    = 10'b00_0000_1000,
    PH_CMD     = 10'b00_0001_0000,
    PH_OPND    = 10'b00_0010_0000,
    PH_LIT     = 10'b00_0100_0000,
    PH_COPY    = 10'b00_1000_0000,
    PH_STOPLIT = 10'b01_0000_0000,
    PH_DONE    = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       copy_pending;
    logic       finished;
    logic [2:0] error;
  } result_t;

endpackage

/* sv/rpd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; a read of an address written in the same cycle returns old data.
module rpd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/rpd_ctrl.sv */
// Stream parser, command decoder and history addressing for the decompressor.
// Depends on rpd_pkg; drives the history RAM ports and returns one result per item.
module rpd_ctrl
  import rpd_pkg::*;
#(
  parameter int unsigned HistDepth = HistDepthDef,
  localparam int unsigned AW = $clog2(HistDepth)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic          cmd,
  input  logic [7:0]    data_byte,
  output result_t       res,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic [AW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata
);

  phase_t              ph_r, ph_nxt;
  logic [2:0]          err_r, err_nxt;
  logic [1:0]          hc_r, hc_nxt;
  logic                skip_r, skip_nxt;
  logic [7:0]          c0_r, c0_nxt, c1_r, c1_nxt, c2_r, c2_nxt;
  logic [6:0]          lit_r, lit_nxt;
  logic [10:0]         cpy_r, cpy_nxt;
  logic [DistW-1:0]    dist_r, dist_nxt;
  logic [CountW-1:0]   oc_r, oc_nxt, dsz_r, dsz_nxt, oc_inc;
  logic [AW-1:0]       ptr_r, ptr_nxt, ptr_inc;
  logic                fwd_r;
  logic [7:0]          fwd_data_r;
  logic [7:0]          hist_byte;
  logic                push;
  logic [7:0]          pbyte;
  logic                has;
  logic [7:0]          ob;
  logic [1:0]          need;
  logic [6:0]          d_lit;
  logic [10:0]         d_cpy;
  logic [DistW-1:0]    d_dist;
  logic [7:0]          stop_n;
  logic [DistW:0]      src;
  logic [AW-1:0]       raddr;

  function automatic logic dist_bad(input logic [DistW-1:0] d, input logic [CountW-1:0] oc);
    dist_bad = ({{(CountW-DistW){1'b0}}, d} > oc) || ({1'b0, d} > (DistW+1)'(HistDepth));
  endfunction

  assign hist_byte = fwd_r ? fwd_data_r : ram_rdata;
  assign oc_inc    = oc_r + 1'b1;
  assign ptr_inc   = (ptr_r == AW'(HistDepth - 1)) ? '0 : ptr_r + 1'b1;
  assign need      = !c0_r[7] ? 2'd1 : (!c0_r[6] ? 2'd2 : 2'd3);
  assign stop_n    = {1'b0, data_byte[4:0], 2'b00} + 8'd4;

  // Operand decode of the two-, three- and four-byte commands.
  always_comb begin
    if (!c0_r[7]) begin
      d_lit  = {5'd0, c0_r[1:0]};
      d_dist = DistW'({c0_r[6:5], 8'h00}) + DistW'(data_byte) + 1'b1;
      d_cpy  = 11'({c0_r[4:2]}) + 11'd3;
    end else if (!c0_r[6]) begin
      d_lit  = {5'd0, c1_r[7:6]};
      d_dist = DistW'({c1_r[5:0], 8'h00}) + DistW'(data_byte) + 1'b1;
      d_cpy  = 11'(c0_r[5:0]) + 11'd4;
    end else begin
      d_lit  = {5'd0, c0_r[1:0]};
      d_dist = DistW'({c0_r[4], c1_r, c2_r}) + 1'b1;
      d_cpy  = 11'({c0_r[3:2], data_byte}) + 11'd5;
    end
  end

  always_comb begin
    ph_nxt   = ph_r;
    err_nxt  = err_r;
    hc_nxt   = hc_r;
    skip_nxt = skip_r;
    c0_nxt   = c0_r;
    c1_nxt   = c1_r;
    c2_nxt   = c2_r;
    lit_nxt  = lit_r;
    cpy_nxt  = cpy_r;
    dist_nxt = dist_r;
    dsz_nxt  = dsz_r;
    push     = 1'b0;
    pbyte    = data_byte;
    has      = 1'b0;
    ob       = '0;
    if (err_r == ErrNone) begin
      if (cmd) begin
        if (ph_r != PH_COPY) begin
          err_nxt = ErrOrder;
        end else if (oc_r >= dsz_r) begin
          err_nxt = ErrOver;
        end else begin
          has     = 1'b1;
          ob      = hist_byte;
          push    = 1'b1;
          pbyte   = hist_byte;
          cpy_nxt = cpy_r - 1'b1;
          if (cpy_r == 11'd1) begin
            ph_nxt = PH_CMD;
          end
        end
      end else begin
        unique case (ph_r) inside
          PH_HDR0: begin
            skip_nxt = data_byte[0];
            ph_nxt   = PH_HDR1;
          end
          PH_HDR1: begin
            if (data_byte != MagicByte) begin
              err_nxt = ErrMagic;
            end else begin
              hc_nxt = '0;
              ph_nxt = skip_r ? PH_SKIP : PH_SIZE;
            end
          end
          PH_SKIP: begin
            hc_nxt = hc_r + 1'b1;
            if (hc_r == 2'd2) begin
              hc_nxt = '0;
              ph_nxt = PH_SIZE;
            end
          end
          PH_SIZE: begin
            dsz_nxt = {dsz_r[15:0], data_byte};
            hc_nxt  = hc_r + 1'b1;
            if (hc_r == 2'd2) begin
              hc_nxt = '0;
              ph_nxt = PH_CMD;
            end
          end
          PH_CMD: begin
            c0_nxt = data_byte;
            hc_nxt = '0;
            if (data_byte[7:5] == 3'b111) begin
              cpy_nxt  = '0;
              dist_nxt = '0;
              if (stop_n <= 8'h70) begin
                lit_nxt = stop_n[6:0];
                ph_nxt  = PH_LIT;
              end else begin
                lit_nxt = {5'd0, data_byte[1:0]};
                ph_nxt  = (data_byte[1:0] != 2'd0) ? PH_STOPLIT : PH_DONE;
              end
            end else begin
              ph_nxt = PH_OPND;
            end
          end
          PH_OPND: begin
            if ({1'b0, hc_r} + 3'd1 >= {1'b0, need}) begin
              hc_nxt   = '0;
              lit_nxt  = d_lit;
              cpy_nxt  = d_cpy;
              dist_nxt = d_dist;
              if (d_lit != '0) begin
                ph_nxt = PH_LIT;
              end else if (d_cpy == '0) begin
                ph_nxt = PH_CMD;
              end else if (dist_bad(d_dist, oc_r)) begin
                err_nxt = ErrDist;
              end else begin
                ph_nxt = PH_COPY;
              end
            end else begin
              hc_nxt = hc_r + 1'b1;
              if (hc_r == 2'd0) begin
                c1_nxt = data_byte;
              end else begin
                c2_nxt = data_byte;
              end
            end
          end
          PH_LIT, PH_STOPLIT: begin
            if (oc_r >= dsz_r) begin
              err_nxt = ErrOver;
            end else begin
              has     = 1'b1;
              ob      = data_byte;
              push    = 1'b1;
              lit_nxt = lit_r - 1'b1;
              if (lit_r == 7'd1) begin
                if (ph_r == PH_STOPLIT) begin
                  ph_nxt = PH_DONE;
                end else if (cpy_r == '0) begin
                  ph_nxt = PH_CMD;
                end else if (dist_bad(dist_r, oc_inc)) begin
                  err_nxt = ErrDist;
                end else begin
                  ph_nxt = PH_COPY;
                end
              end
            end
          end
          default: begin
            err_nxt = ErrOrder;
          end
        endcase
      end
    end
    oc_nxt  = push ? oc_inc : oc_r;
    ptr_nxt = push ? ptr_inc : ptr_r;
  end

  // Prefetch the byte the next drain item would read, from the state after this cycle.
  always_comb begin
    logic [AW-1:0]    p;
    logic [DistW-1:0] d;
    p   = acc ? ptr_nxt : ptr_r;
    d   = acc ? dist_nxt : dist_r;
    src = {1'b0, DistW'(p)} - {1'b0, d};
    if (src[DistW]) begin
      src = src + (DistW+1)'(HistDepth);
    end
    raddr = src[AW-1:0];
  end

  assign ram_raddr = raddr;
  assign ram_we    = acc && push;
  assign ram_waddr = ptr_r;
  assign ram_wdata = pbyte;

  assign res.has_byte     = has;
  assign res.out_byte     = ob;
  assign res.copy_pending = (ph_nxt == PH_COPY) && (err_nxt == ErrNone);
  assign res.finished     = (ph_nxt == PH_DONE);
  assign res.error        = err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_HDR0;
      err_r  <= ErrNone;
      hc_r   <= '0;
      skip_r <= 1'b0;
      c0_r   <= '0;
      c1_r   <= '0;
      c2_r   <= '0;
      lit_r  <= '0;
      cpy_r  <= '0;
      dist_r <= '0;
      oc_r   <= '0;
      dsz_r  <= '0;
      ptr_r  <= '0;
      fwd_r  <= 1'b0;
    end else begin
      fwd_r <= ram_we && (raddr == ptr_r);
      if (acc) begin
        ph_r   <= ph_nxt;
        err_r  <= err_nxt;
        hc_r   <= hc_nxt;
        skip_r <= skip_nxt;
        c0_r   <= c0_nxt;
        c1_r   <= c1_nxt;
        c2_r   <= c2_nxt;
        lit_r  <= lit_nxt;
        cpy_r  <= cpy_nxt;
        dist_r <= dist_nxt;
        oc_r   <= oc_nxt;
        dsz_r  <= dsz_nxt;
        ptr_r  <= ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= pbyte;
  end

endmodule

/* sv/refpack_stream_decompressor_core.sv */
// Top level of the RefPack stream decompressor: handshakes, output register, history RAM.
// Depends on rpd_pkg, rpd_ram and rpd_ctrl.
//
//  channel | direction | tdata                                   | tuser
//  in_     | slave     | data_byte[7:0]                          | cmd
//  out_    | master    | out_byte, copy_pending, finished, error | has_byte
//
// A new item is taken every cycle while the result register is empty or being
// drained. The rate is set by the single history RAM read port, which prefetches
// the next copy source from the state after every item, with a forwarding
// register covering a byte written in that same cycle.
// Reset (synchronous, rst_n low) clears parser state; the RAM is not cleared.
// A stall on out_ holds the result and stops in_ until the result is taken.
module refpack_stream_decompressor_core
  import rpd_pkg::*;
#(
  parameter int unsigned HistDepth = HistDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] copy_pending, [9] finished,
                                  // [12:10] error, [15:13] zero
  output logic        out_tuser   // [0] has_byte
);

  localparam int unsigned AW = $clog2(HistDepth);

  logic          acc;
  result_t       res;
  result_t       res_r;
  logic          ovalid_r;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // Take a new item whenever the result register is free or emptying this cycle.
  assign in_tready = !ovalid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  rpd_ctrl #(
    .HistDepth(HistDepth)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .cmd      (in_tuser),
    .data_byte(in_tdata),
    .res      (res),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  rpd_ram #(
    .Width(8),
    .Depth(HistDepth)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Result register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (acc) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = res_r.has_byte;
  assign out_tdata  = {3'b000, res_r.error, res_r.finished, res_r.copy_pending,
                       res_r.out_byte};

endmodule
